FILE: rtl/core/f2i64_pkg.sv
// ----------------------------------------------------------------------------
// f2i64_pkg
// Shared types and constants of the float to int64 saturating converter.
// ----------------------------------------------------------------------------
package f2i64_pkg;

	localparam int unsigned ShiftW = 6;

	localparam logic [63:0] Int64MaxBits = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] Int64MinBits = 64'h8000_0000_0000_0000;

	localparam logic REQ_SINGLE = 1'b0;
	localparam logic REQ_DOUBLE = 1'b1;

	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_SAT  = 2'd1,
		CLS_NORM = 2'd2
	} cls_t;

	// Decoded operand, carried from the decode stage to the shift stage.
	typedef struct packed {
		logic              neg;
		cls_t              cls;
		logic              left;   // 1: shift significand left, 0: right
		logic [ShiftW-1:0] amt;    // shift distance
		logic [52:0]       sig;    // significand, hidden bit at 52 (double) or 23
	} dec_t;

endpackage

FILE: rtl/core/f2i64_if.sv
// ----------------------------------------------------------------------------
// f2i64_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface f2i64_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/float_to_int64_saturating_convert.sv
// ----------------------------------------------------------------------------
// float_to_int64_saturating_convert
// Single/double IEEE-754 to int64, truncating, saturating, NaN to zero.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while out_ch.ready stays high; stages: decode, align, negate/saturate.
// A stall holds every stage whose successor is full; in.ready falls only then.
// Reset clears the stage valid bits; payload registers are not reset.
module float_to_int64_saturating_convert (
	input  logic       clk,
	input  logic       arst_n,
	f2i64_if.sink      in_ch,
	f2i64_if.source    out_ch
);
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	f2i64_pkg::dec_t dec_c, dec_s1;
	f2i64_pkg::dec_t dec_s2;
	logic [63:0] mag_c, mag_s2, res_s3;
	logic [63:0] res_c;

	assign en3          = !v_s3 || out_ch.ready;
	assign en2          = !v_s2 || en3;
	assign en1          = !v_s1 || en2;
	assign in_ch.ready  = en1;
	assign out_ch.valid = v_s3;
	assign out_ch.data  = res_s3;

	f2i64_dec u_dec (
		.req_type   (in_ch.data[64]),
		.value_bits (in_ch.data[63:0]),
		.dec        (dec_c)
	);

	f2i64_shf u_shf (
		.dec (dec_s1),
		.mag (mag_c)
	);

	always_comb begin
		unique case (dec_s2.cls)
			f2i64_pkg::CLS_SAT:
				res_c = dec_s2.neg ? f2i64_pkg::Int64MinBits : f2i64_pkg::Int64MaxBits;
			f2i64_pkg::CLS_NORM:
				res_c = dec_s2.neg ? (64'd0 - mag_s2) : mag_s2;
			default:
				res_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_ch.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) dec_s1 <= dec_c;
		if (en2) begin
			dec_s2 <= dec_s1;
			mag_s2 <= mag_c;
		end
		if (en3) res_s3 <= res_c;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("output item changed under stall");
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en3 && v_s2 && dec_s2.cls == f2i64_pkg::CLS_ZERO |=> res_s3 == '0)
		else $error("zero class gave nonzero result");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ch.ready)
		else $error("input stalled with empty first stage");
endmodule

FILE: rtl/core/f2i64_dec.sv
// ----------------------------------------------------------------------------
// f2i64_dec
// Field split, classification and shift distance of the operand.
// ----------------------------------------------------------------------------
module f2i64_dec (
	input  logic                 req_type,
	input  logic [63:0]          value_bits,
	output f2i64_pkg::dec_t      dec
);
	logic        neg;
	logic [10:0] expf;
	logic [51:0] frac;
	logic        all_ones;
	logic [11:0] e;      // unbiased exponent, signed
	logic [5:0]  fbits;

	always_comb begin
		if (req_type == f2i64_pkg::REQ_DOUBLE) begin
			neg      = value_bits[63];
			expf     = value_bits[62:52];
			frac     = value_bits[51:0];
			all_ones = &value_bits[62:52];
			e        = {1'b0, value_bits[62:52]} - 12'd1023;
			fbits    = 6'd52;
		end else begin
			neg      = value_bits[31];
			expf     = {3'b0, value_bits[30:23]};
			frac     = {29'b0, value_bits[22:0]};
			all_ones = &value_bits[30:23];
			e        = {4'b0, value_bits[30:23]} - 12'd127;
			fbits    = 6'd23;
		end
	end

	always_comb begin
		dec.neg  = neg;
		dec.sig  = (req_type == f2i64_pkg::REQ_DOUBLE) ? {1'b1, frac}
			: {29'b0, 1'b1, frac[22:0]};
		dec.left = 1'b0;
		dec.amt  = '0;
		if (all_ones) begin
			dec.cls = (frac != '0) ? f2i64_pkg::CLS_ZERO : f2i64_pkg::CLS_SAT;
		end else if (e[11]) begin
			dec.cls = f2i64_pkg::CLS_ZERO;
		end else if (e >= 12'd63) begin
			dec.cls = f2i64_pkg::CLS_SAT;
		end else begin
			dec.cls = f2i64_pkg::CLS_NORM;
			if (e[5:0] >= fbits) begin
				dec.left = 1'b1;
				dec.amt  = e[5:0] - fbits;
			end else begin
				dec.amt  = fbits - e[5:0];
			end
		end
		// expf serves only the zero check below
		if (expf == '0 && frac == '0) dec.cls = f2i64_pkg::CLS_ZERO;
	end
endmodule

FILE: rtl/core/f2i64_shf.sv
// ----------------------------------------------------------------------------
// f2i64_shf
// Significand alignment to an unsigned 64-bit magnitude.
// ----------------------------------------------------------------------------
module f2i64_shf (
	input  f2i64_pkg::dec_t dec,
	output logic [63:0]     mag
);
	logic [63:0] sig_w;

	always_comb begin
		sig_w = {11'b0, dec.sig};
		mag   = dec.left ? (sig_w << dec.amt) : (sig_w >> dec.amt);
	end
endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bench for the float to int64 saturating converter: single and double
// operands, directed corner values then biased random ones, checked in order
// against a bit-field model of truncation, saturation and NaN to zero.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic        req_type;
		logic [63:0] value_bits;
	} conv_req_t;

	typedef struct packed {
		logic [63:0] int_result;
	} conv_res_t;

	typedef struct {
		conv_req_t req;
		bit        hold;   // wait for every result before sending
	} pend_t;

	localparam int WatchdogLimit = 4000;

	logic clk;
	logic arst_n;

	f2i64_if #(.T(conv_req_t)) in_if ();
	f2i64_if #(.T(conv_res_t)) out_if ();

	float_to_int64_saturating_convert u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if.sink),
		.out_ch (out_if.source)
	);

	pend_t       pending_q[$];
	logic [63:0] int_expect_q[$];
	int          src_idle_pct;
	int          snk_idle_pct;
	int          n_accepted;
	int          n_results;
	int          n_errors;
	int          n_single;
	int          n_sat;
	int          n_nan;
	int          quiet_cycles;

	// Truncate toward zero, saturate at the int64 limits, NaN gives zero.
	function automatic logic [63:0] trunc_sat_int64(input logic kind, input logic [63:0] v);
		logic        neg;
		int          ex;
		int          bias;
		int          fbits;
		int          ex_max;
		int          e;
		logic [63:0] frac;
		logic [63:0] sig;
		logic [63:0] mag;
		if (kind == f2i64_pkg::REQ_SINGLE) begin
			neg    = v[31];
			ex     = int'(v[30:23]);
			frac   = {41'd0, v[22:0]};
			bias   = 127;
			fbits  = 23;
			ex_max = 255;
		end else begin
			neg    = v[63];
			ex     = int'(v[62:52]);
			frac   = {12'd0, v[51:0]};
			bias   = 1023;
			fbits  = 52;
			ex_max = 2047;
		end
		if (ex == ex_max)
			return (frac != 0) ? 64'd0
				: (neg ? f2i64_pkg::Int64MinBits : f2i64_pkg::Int64MaxBits);
		if (ex < bias)
			return 64'd0;
		e = ex - bias;
		if (e >= 63)
			return neg ? f2i64_pkg::Int64MinBits : f2i64_pkg::Int64MaxBits;
		sig = (64'd1 << fbits) | frac;
		mag = (e >= fbits) ? (sig << (e - fbits)) : (sig >> (fbits - e));
		return neg ? (64'd0 - mag) : mag;
	endfunction

	function automatic conv_req_t rand_req();
		conv_req_t r;
		int        sel;
		r.req_type   = 1'($urandom_range(1, 0));
		r.value_bits = {$urandom(), $urandom()};
		sel          = $urandom_range(9, 0);
		if (r.req_type == f2i64_pkg::REQ_SINGLE) begin
			if (sel <= 5)
				r.value_bits[30:23] = 8'(122 + $urandom_range(70, 0));
			else if (sel == 6) begin
				r.value_bits[30:23] = 8'hFF;
				if ($urandom_range(1, 0)) r.value_bits[22:0] = '0;
			end else if (sel == 7)
				r.value_bits[30:23] = 8'h00;
		end else begin
			if (sel <= 5)
				r.value_bits[62:52] = 11'(1018 + $urandom_range(70, 0));
			else if (sel == 6) begin
				r.value_bits[62:52] = 11'h7FF;
				if ($urandom_range(1, 0)) r.value_bits[51:0] = '0;
			end else if (sel == 7)
				r.value_bits[62:52] = 11'h000;
		end
		return r;
	endfunction

	task automatic add_item(input logic kind, input logic [63:0] v, input bit hold = 1'b0);
		pend_t p;
		p.req.req_type   = kind;
		p.req.value_bits = v;
		p.hold           = hold;
		pending_q.push_back(p);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		in_if.valid   = 1'b0;
		in_if.data    = '0;
		out_if.ready  = 1'b0;
		src_idle_pct  = 38;
		snk_idle_pct  = 73;
		n_accepted    = 0;
		n_results     = 0;
		n_errors      = 0;
		n_single      = 0;
		n_sat         = 0;
		n_nan         = 0;
		quiet_cycles  = 0;
		arst_n        = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// single precision corners, upper garbage included
		add_item(f2i64_pkg::REQ_SINGLE, 64'h0000_0000_0000_0000);
		add_item(f2i64_pkg::REQ_SINGLE, 64'hFFFF_FFFF_8000_0000);
		add_item(f2i64_pkg::REQ_SINGLE, 64'h0000_0000_3F80_0000);
		add_item(f2i64_pkg::REQ_SINGLE, 64'h1234_5678_BFC0_0000);
		add_item(f2i64_pkg::REQ_SINGLE, 64'h0000_0000_3F00_0000);
		add_item(f2i64_pkg::REQ_SINGLE, 64'h0000_0000_5E80_0001);
		add_item(f2i64_pkg::REQ_SINGLE, 64'h0000_0000_5F00_0000);
		add_item(f2i64_pkg::REQ_SINGLE, 64'h0000_0000_DF00_0000);
		add_item(f2i64_pkg::REQ_SINGLE, 64'h0000_0000_7F7F_FFFF);
		add_item(f2i64_pkg::REQ_SINGLE, 64'h0000_0000_7F80_0000);
		add_item(f2i64_pkg::REQ_SINGLE, 64'h0000_0000_FF80_0000);
		add_item(f2i64_pkg::REQ_SINGLE, 64'h0000_0000_7FC0_0000);
		add_item(f2i64_pkg::REQ_SINGLE, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(f2i64_pkg::REQ_SINGLE, 64'hFFFF_FFFF_0000_0001);
		// double precision corners
		add_item(f2i64_pkg::REQ_DOUBLE, 64'h3FF0_0000_0000_0000);
		add_item(f2i64_pkg::REQ_DOUBLE, 64'hC005_9999_9999_999A);
		add_item(f2i64_pkg::REQ_DOUBLE, 64'h4330_0000_0000_0001);
		add_item(f2i64_pkg::REQ_DOUBLE, 64'h43DF_FFFF_FFFF_FFFF);
		add_item(f2i64_pkg::REQ_DOUBLE, 64'h43E0_0000_0000_0000);
		add_item(f2i64_pkg::REQ_DOUBLE, 64'hC3E0_0000_0000_0000);
		add_item(f2i64_pkg::REQ_DOUBLE, 64'h7FF0_0000_0000_0000);
		add_item(f2i64_pkg::REQ_DOUBLE, 64'hFFF0_0000_0000_0000);
		add_item(f2i64_pkg::REQ_DOUBLE, 64'hFFF0_0000_0000_0001);
		add_item(f2i64_pkg::REQ_DOUBLE, 64'h8000_0000_0000_0001);
		add_item(f2i64_pkg::REQ_DOUBLE, 64'h7FEF_FFFF_FFFF_FFFF);
		for (int i = 0; i < 450; i++) begin
			pend_t p;
			p.req  = rand_req();
			p.hold = (i == 100 || i == 330);
			pending_q.push_back(p);
		end

		wait (n_accepted >= 160);
		src_idle_pct = 73;
		snk_idle_pct = 38;
		wait (n_accepted >= 320);
		src_idle_pct = 0;
		snk_idle_pct = 0;

		wait (pending_q.size() == 0 && !in_if.valid && int_expect_q.size() == 0);
		repeat (10) @(posedge clk);
		$display("%0d items: %0d single, %0d saturated, %0d NaN; %0d results checked",
			n_accepted, n_single, n_sat, n_nan, n_results);
		if (n_errors == 0 && int_expect_q.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// sender
	always @(posedge clk) begin
		bit fire;
		bit drained;
		fire    = in_if.valid && in_if.ready;
		drained = (n_accepted + int'(fire)) == n_results;
		if (!arst_n) begin
			in_if.valid <= 1'b0;
		end else if (!in_if.valid || fire) begin
			if (pending_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct
					&& (!pending_q[0].hold || (drained && int_expect_q.size() == 0))) begin
				in_if.valid <= 1'b1;
				in_if.data  <= pending_q.pop_front().req;
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	// input side bookkeeping, receiver stalls, result check
	always @(posedge clk) begin
		logic [63:0] want;
		if (in_if.valid && in_if.ready) begin
			want = trunc_sat_int64(in_if.data.req_type, in_if.data.value_bits);
			int_expect_q.push_back(want);
			n_accepted <= n_accepted + 1;
			if (in_if.data.req_type == f2i64_pkg::REQ_SINGLE) n_single <= n_single + 1;
			if (want == f2i64_pkg::Int64MaxBits || want == f2i64_pkg::Int64MinBits)
				n_sat <= n_sat + 1;
		end
		if (arst_n)
			out_if.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
		if (out_if.valid && out_if.ready) begin
			n_results <= n_results + 1;
			if (int_expect_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h",
					$time, out_if.data.int_result);
				n_errors <= n_errors + 1;
			end else begin
				want = int_expect_q.pop_front();
				if (out_if.data.int_result !== want) begin
					$display("%0t: int_result mismatch, expected %h, actual %h",
						$time, want, out_if.data.int_result);
					n_errors <= n_errors + 1;
				end
			end
		end
	end

	// NaN count, taken from accepted operands
	always @(posedge clk) begin
		if (in_if.valid && in_if.ready) begin
			if (in_if.data.req_type == f2i64_pkg::REQ_SINGLE
					? (in_if.data.value_bits[30:23] == 8'hFF && in_if.data.value_bits[22:0] != 0)
					: (in_if.data.value_bits[62:52] == 11'h7FF
						&& in_if.data.value_bits[51:0] != 0))
				n_nan <= n_nan + 1;
		end
	end

	// watchdog: too long with nothing moving on either side
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("%0t: watchdog expired, %0d results outstanding",
				$time, int_expect_q.size());
			$display("tb NOT OK");
			$finish;
		end
	end

endmodule

FILE: float_to_int64_saturating_convert.f
rtl/core/f2i64_pkg.sv
rtl/core/f2i64_if.sv
rtl/core/f2i64_dec.sv
rtl/core/f2i64_shf.sv
rtl/core/float_to_int64_saturating_convert.sv
bench/tb.sv
